/* rtl/core/work_pool_deque_bulk_steal_defines.svh */
// assertion macros shared by the checker
`ifndef WORK_POOL_DEQUE_BULK_STEAL_DEFINES_SVH
`define WORK_POOL_DEQUE_BULK_STEAL_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define WPDBS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define WPDBS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/wpdbs_pkg.sv */
package wpdbs_pkg;

	localparam int DEPTH     = 1024;
	localparam int ITEM_BITS = 64;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int DATA_W    = 64;
	localparam int COUNT_W   = 11;
	localparam int MAX_OUT   = 64;
	localparam int BATCH_W   = $clog2(MAX_OUT + 1);
	localparam int MINB_W    = 7;
	localparam int MAXB_W    = 7;
	localparam int FRAC_W    = 9;
	localparam int CFG_W     = 9;
	localparam int CFGI_W    = 2;
	localparam int CMD_W     = 3;
	localparam int WIDE_W    = (CNT_W > MINB_W + 1) ? CNT_W : MINB_W + 1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QOCC_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int OUT_DEPTH   = 2;
	localparam int OPTR_W      = $clog2(OUT_DEPTH);
	localparam int OOCC_W      = $clog2(OUT_DEPTH + 1);

	localparam logic [CMD_W-1:0] CMD_PUSH       = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_BULK_BACK  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_HALF_BACK  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_BULK_FRONT = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic [CFGI_W-1:0] CFG_MIN_BATCH = 2'd0;
	localparam logic [CFGI_W-1:0] CFG_MAX_BATCH = 2'd1;
	localparam logic [CFGI_W-1:0] CFG_FRACTION  = 2'd2;

	localparam logic [1:0] JOB_NOTE  = 2'd0;
	localparam logic [1:0] JOB_WRITE = 2'd1;
	localparam logic [1:0] JOB_READ  = 2'd2;

	typedef struct packed {
		logic [1:0]           kind;
		logic [ADDR_W-1:0]    addr;
		logic [BATCH_W-1:0]   n;
		logic [COUNT_W-1:0]   count;
		logic [1:0]           status;
		logic [ITEM_BITS-1:0] data;
	} job_t;

	typedef struct packed {
		logic [ITEM_BITS-1:0] item;
		logic                 has_work;
		logic [COUNT_W-1:0]   count;
		logic [1:0]           status;
		logic                 last;
	} res_t;

endpackage

/* rtl/core/wpdbs_ram.sv */
module wpdbs_ram #(
	parameter int WIDTH = 64,
	parameter int WORDS = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(WORDS)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

/* rtl/core/wpdbs_queue.sv */
module wpdbs_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  wpdbs_pkg::job_t job_in,
	output logic            full,
	output logic            valid,
	output wpdbs_pkg::job_t job_out,
	input  logic            pop
);

	import wpdbs_pkg::*;

	job_t              ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QOCC_W-1:0] occ_q;
	logic              do_push;
	logic              do_pop;

	assign full    = occ_q == QOCC_W'(QUEUE_DEPTH);
	assign valid   = occ_q != '0;
	assign job_out = ent_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			occ_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			occ_q <= occ_q + QOCC_W'(do_push) - QOCC_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= job_in;
		end
	end

endmodule

/* rtl/core/wpdbs_front.sv */
module wpdbs_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [wpdbs_pkg::CMD_W-1:0]          cmd,
	input  logic [wpdbs_pkg::DATA_W-1:0]         node_data,
	input  logic                                 cfg_we,
	input  logic [wpdbs_pkg::CFGI_W-1:0]         cfg_index,
	input  logic [wpdbs_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                 q_full,
	output logic                                 job_push,
	output wpdbs_pkg::job_t                      job
);

	import wpdbs_pkg::*;

	logic [ADDR_W-1:0]        head_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [MINB_W-1:0]        min_q;
	logic [MAXB_W-1:0]        max_q;
	logic [FRAC_W-1:0]        frac_q;

	logic                     accept;
	logic [WIDE_W-1:0]        cnt_w;
	logic [WIDE_W-1:0]        min1_w;
	logic [WIDE_W-1:0]        min2_w;
	logic [CNT_W+FRAC_W-1:0]  prod;
	logic [CNT_W:0]           share;
	logic [CNT_W-1:0]         share_cap;
	logic [CNT_W-1:0]         back_src;
	logic [BATCH_W-1:0]       take_back;
	logic [BATCH_W-1:0]       take_front;
	logic [CNT_W-1:0]         cnt_after_back;
	logic [ADDR_W-1:0]        head_nxt;
	logic [CNT_W-1:0]         cnt_nxt;
	logic                     emit;

	function automatic logic [BATCH_W-1:0] clamp_batch(
		input logic [CNT_W-1:0]  x,
		input logic [MAXB_W-1:0] mx
	);
		logic [WIDE_W+BATCH_W-1:0] lim;
		logic [WIDE_W+BATCH_W-1:0] xw;
		lim = ((WIDE_W + BATCH_W)'(mx) < (WIDE_W + BATCH_W)'(MAX_OUT)) ?
			(WIDE_W + BATCH_W)'(mx) : (WIDE_W + BATCH_W)'(MAX_OUT);
		xw  = (WIDE_W + BATCH_W)'(x);
		return (xw < lim) ? BATCH_W'(xw) : BATCH_W'(lim);
	endfunction

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		cnt_w          = WIDE_W'(cnt_q);
		min1_w         = WIDE_W'(min_q);
		min2_w         = WIDE_W'({min_q, 1'b0});
		prod           = {{FRAC_W{1'b0}}, cnt_q} * {{CNT_W{1'b0}}, frac_q};
		share          = prod[CNT_W+FRAC_W-1:FRAC_W-1];
		share_cap      = (share > {1'b0, cnt_q}) ? cnt_q : share[CNT_W-1:0];
		back_src       = (cmd == CMD_BULK_BACK) ? cnt_q : (cnt_q >> 1);
		take_back      = clamp_batch(back_src, max_q);
		take_front     = clamp_batch(share_cap, max_q);
		cnt_after_back = cnt_q - CNT_W'(take_back);

		head_nxt    = head_q;
		cnt_nxt     = cnt_q;
		emit        = 1'b1;
		job.kind    = JOB_NOTE;
		job.addr    = head_q;
		job.n       = '0;
		job.count   = '0;
		job.status  = ST_OK;
		job.data    = node_data[ITEM_BITS-1:0];

		unique case (cmd)
			CMD_PUSH: begin
				if (cnt_q == CNT_W'(DEPTH)) begin
					job.status = ST_FULL;
				end else begin
					job.kind = JOB_WRITE;
					job.addr = head_q + cnt_q[ADDR_W-1:0];
					cnt_nxt  = cnt_q + 1'b1;
				end
			end
			CMD_POP_BACK: begin
				if (cnt_q == '0) begin
					job.status = ST_EMPTY;
				end else begin
					job.kind = JOB_READ;
					job.n    = BATCH_W'(1);
					cnt_nxt  = cnt_q - 1'b1;
					job.addr = head_q + cnt_nxt[ADDR_W-1:0];
				end
			end
			CMD_BULK_BACK, CMD_HALF_BACK: begin
				if ((cmd == CMD_BULK_BACK && cnt_w < min1_w) ||
				    (cmd == CMD_HALF_BACK && cnt_w < min2_w)) begin
					job.status = ST_EMPTY;
					job.count  = COUNT_W'(cnt_q);
				end else if (take_back != '0) begin
					job.kind  = JOB_READ;
					job.n     = take_back;
					job.count = COUNT_W'(take_back);
					job.addr  = head_q + cnt_after_back[ADDR_W-1:0];
					cnt_nxt   = cnt_after_back;
				end
			end
			CMD_POP_FRONT: begin
				if (cnt_q == '0) begin
					job.status = ST_EMPTY;
				end else begin
					job.kind = JOB_READ;
					job.n    = BATCH_W'(1);
					head_nxt = head_q + 1'b1;
					cnt_nxt  = cnt_q - 1'b1;
				end
			end
			CMD_BULK_FRONT: begin
				if (cnt_w < min2_w) begin
					job.status = ST_EMPTY;
					job.count  = COUNT_W'(cnt_q);
				end else if (take_front != '0) begin
					job.kind  = JOB_READ;
					job.n     = take_front;
					job.count = COUNT_W'(take_front);
					head_nxt  = head_q + ADDR_W'(take_front);
					cnt_nxt   = cnt_q - CNT_W'(take_front);
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign job_push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
			min_q  <= MINB_W'(1);
			max_q  <= MAXB_W'(64);
			frac_q <= FRAC_W'(128);
		end else begin
			if (accept) begin
				head_q <= head_nxt;
				cnt_q  <= cnt_nxt;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MIN_BATCH: min_q  <= cfg_data[MINB_W-1:0];
					CFG_MAX_BATCH: max_q  <= cfg_data[MAXB_W-1:0];
					CFG_FRACTION:  frac_q <= cfg_data[FRAC_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

endmodule

/* rtl/core/wpdbs_back.sv */
module wpdbs_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	input  wpdbs_pkg::job_t job,
	output logic            job_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output wpdbs_pkg::res_t res
);

	import wpdbs_pkg::*;

	logic [BATCH_W-1:0]   idx_q;
	logic                 v_s1;
	res_t                 meta_s1;
	res_t                 ent_q [OUT_DEPTH];
	logic [OPTR_W-1:0]    wr_q;
	logic [OPTR_W-1:0]    rd_q;
	logic [OOCC_W-1:0]    occ_q;

	logic                 pop;
	logic [OOCC_W:0]      used;
	logic [OOCC_W:0]      cap;
	logic                 issue;
	logic                 is_read;
	logic                 last_item;
	logic                 ram_en;
	logic [ADDR_W-1:0]    ram_addr;
	logic [ITEM_BITS-1:0] ram_rdata;
	res_t                 land;

	assign out_valid = occ_q != '0;
	assign pop       = out_valid && out_ready;
	assign res       = ent_q[rd_q];

	// a result slot must be free when the stage-one result lands
	assign used      = {1'b0, occ_q} + (OOCC_W + 1)'(v_s1);
	assign cap       = (OOCC_W + 1)'(OUT_DEPTH) + (OOCC_W + 1)'(pop);
	assign issue     = job_valid && (used < cap);
	assign is_read   = job.kind == JOB_READ;
	assign last_item = !is_read || (BATCH_W'(idx_q + 1'b1) == job.n);
	assign job_pop   = issue && last_item;
	assign ram_en    = issue && (job.kind != JOB_NOTE);
	assign ram_addr  = is_read ? job.addr + ADDR_W'(idx_q) : job.addr;

	wpdbs_ram #(
		.WIDTH(ITEM_BITS),
		.WORDS(DEPTH)
	) u_store (
		.clk  (clk),
		.en   (ram_en),
		.we   (job.kind == JOB_WRITE),
		.addr (ram_addr),
		.wdata(job.data),
		.rdata(ram_rdata)
	);

	always_comb begin
		land      = meta_s1;
		land.item = meta_s1.has_work ? ram_rdata : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			v_s1  <= 1'b0;
			wr_q  <= '0;
			rd_q  <= '0;
			occ_q <= '0;
		end else begin
			v_s1 <= issue;
			if (issue && is_read) begin
				idx_q <= last_item ? '0 : idx_q + 1'b1;
			end
			if (v_s1) begin
				wr_q <= (wr_q == OPTR_W'(OUT_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == OPTR_W'(OUT_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			occ_q <= occ_q + OOCC_W'(v_s1) - OOCC_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			meta_s1.item     <= '0;
			meta_s1.has_work <= is_read;
			meta_s1.count    <= job.count;
			meta_s1.status   <= job.status;
			meta_s1.last     <= last_item;
		end
		if (v_s1) begin
			ent_q[wr_q] <= land;
		end
	end

endmodule

/* rtl/core/work_pool_deque_bulk_steal.sv */
// Ring deque of work items with single and bulk removal from either end. Pushes,
// single pops and refused or empty commands each make one pass of the back end;
// a bulk pop holds the back end for one access per removed item (up to 64), since
// every item is one access of the single-port item store. The front end accepts a
// new item each cycle while the two-entry job queue has room, so input stalls only
// behind a bulk pop in progress or a full result buffer. Results come out of a
// two-entry buffer in command order, a bulk pop in ascending store address order
// with last on its final item. The store needs no clearing after reset.
module work_pool_deque_bulk_steal (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [wpdbs_pkg::CMD_W-1:0]    cmd,
	input  logic [wpdbs_pkg::DATA_W-1:0]   node_data,
	input  logic                           cfg_we,
	input  logic [wpdbs_pkg::CFGI_W-1:0]   cfg_index,
	input  logic [wpdbs_pkg::CFG_W-1:0]    cfg_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [wpdbs_pkg::DATA_W-1:0]   item_out,
	output logic                           has_work,
	output logic [wpdbs_pkg::COUNT_W-1:0]  count,
	output logic [1:0]                     status,
	output logic                           last
);

	import wpdbs_pkg::*;

	logic q_full;
	logic job_push;
	job_t job_in;
	logic job_valid;
	job_t job_head;
	logic job_pop;
	res_t res;

	wpdbs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.node_data(node_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_full   (q_full),
		.job_push (job_push),
		.job      (job_in)
	);

	wpdbs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.job_in (job_in),
		.full   (q_full),
		.valid  (job_valid),
		.job_out(job_head),
		.pop    (job_pop)
	);

	wpdbs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(job_valid),
		.job      (job_head),
		.job_pop  (job_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.res      (res)
	);

	assign item_out = DATA_W'(res.item);
	assign has_work = res.has_work;
	assign count    = res.count;
	assign status   = res.status;
	assign last     = res.last;

endmodule

/* rtl/core/wpdbs_checker.sv */
`include "work_pool_deque_bulk_steal_defines.svh"

module wpdbs_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [wpdbs_pkg::DATA_W-1:0]   item_out,
	input logic                           has_work,
	input logic [wpdbs_pkg::COUNT_W-1:0]  count,
	input logic [1:0]                     status,
	input logic                           last
);

	import wpdbs_pkg::*;

	`WPDBS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(item_out) && $stable(last) && $stable(count),
		"result changed while stalled")

	`WPDBS_ASSERT_NOW(a_no_work_zero, out_valid && !has_work, item_out == '0,
		"item without work is not zero")

	`WPDBS_ASSERT_NOW(a_work_ok, out_valid && has_work, status == ST_OK,
		"removed item with bad status")

	`WPDBS_ASSERT_NOW(a_burst_body, out_valid && !last, has_work && count != '0,
		"non-final result outside a bulk pop")

	`WPDBS_ASSERT_NOW(a_full_drop, out_valid && status == ST_FULL,
		last && !has_work && count == '0, "dropped push result malformed")

endmodule

bind work_pool_deque_bulk_steal wpdbs_checker u_wpdbs_checker (.*);
